// ===== sv/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/sbre_pkg.sv =====
package sbre_pkg;

  localparam int MAX_BITMAP_BYTES = 1048576;
  localparam int BYTE_W = 8;
  localparam int IDX_W = 24;
  localparam int OFS_W = 36;
  localparam int POS_W = $clog2(BYTE_W);

  // Highest base sector index that still leaves room for one more byte.
  localparam logic [IDX_W-1:0] LAST_BASE = IDX_W'(MAX_BITMAP_BYTES * BYTE_W - BYTE_W);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_MSB_FIRST = 1'b0,
    CFG_SECTOR_4K = 1'b1
  } cfg_index_t;

  typedef logic [IDX_W-1:0] idx_t;

  // One classified bitmap byte, handed from the front end to the range emitter.
  typedef struct packed {
    logic [BYTE_W-1:0] flags;      // sector flags in sector order
    logic [BYTE_W-1:0] chg;        // flag changes at each sector of the byte
    idx_t              base;       // sector index of the byte's first flag
    idx_t              run_start;  // start of the run open before this byte
    idx_t              end_index;  // sector count after this byte
    logic              final_bit;  // flag value of the run open after this byte
    logic              fin;        // byte closes the bitmap
    logic              ovf;        // overflow seen in this bitmap so far
  } run_entry_t;

endpackage

// ===== sv/sbre_front.sv =====
module sbre_front
  import sbre_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              msb_first,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              in_fin,
  output logic              push,
  input  logic              push_ready,
  output run_entry_t        entry
);

  logic run_bit, run_bit_next;
  idx_t run_start, run_start_next;
  idx_t sector_count, sector_count_next;
  logic in_bitmap, in_bitmap_next;
  logic overflow_seen, overflow_seen_next;

  logic [BYTE_W-1:0] f;
  logic [BYTE_W-1:0] chg;
  logic [POS_W-1:0]  hp;
  logic              starting;
  logic              skip;
  logic              rb;
  logic              ov;
  idx_t              rs;
  idx_t              sc;

  function automatic logic [POS_W-1:0] highest_set(logic [BYTE_W-1:0] m);
    logic [POS_W-1:0] r;
    r = '0;
    for (int i = 0; i < BYTE_W; i++) begin
      if (m[i]) r = POS_W'(i);
    end
    return r;
  endfunction

  assign in_ready = push_ready;
  assign push     = in_valid && push_ready;

  always_comb begin
    for (int i = 0; i < BYTE_W; i++) begin
      f[i] = msb_first ? in_byte[BYTE_W-1-i] : in_byte[i];
    end
    starting = !in_bitmap;
    rb   = starting ? f[0] : run_bit;
    rs   = starting ? '0 : run_start;
    sc   = starting ? '0 : sector_count;
    ov   = starting ? 1'b0 : overflow_seen;
    skip = sc > LAST_BASE;
    chg  = skip ? '0 : (f ^ {f[BYTE_W-2:0], rb});
    hp   = highest_set(chg);

    run_bit_next       = skip ? rb : f[BYTE_W-1];
    run_start_next     = (chg != '0) ? sc + idx_t'(hp) : rs;
    sector_count_next  = skip ? sc : sc + idx_t'(BYTE_W);
    overflow_seen_next = ov | skip;
    in_bitmap_next     = !in_fin;
  end

  always_comb begin
    entry.flags     = f;
    entry.chg       = chg;
    entry.base      = sc;
    entry.run_start = rs;
    entry.end_index = sector_count_next;
    entry.final_bit = run_bit_next;
    entry.fin       = in_fin;
    entry.ovf       = overflow_seen_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_bit       <= 1'b0;
      run_start     <= '0;
      sector_count  <= '0;
      in_bitmap     <= 1'b0;
      overflow_seen <= 1'b0;
    end else if (push) begin
      run_bit       <= run_bit_next;
      run_start     <= run_start_next;
      sector_count  <= sector_count_next;
      in_bitmap     <= in_bitmap_next;
      overflow_seen <= overflow_seen_next;
    end
  end

endmodule

// ===== sv/sbre_queue.sv =====
module sbre_queue
  import sbre_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       push_ready,
  input  run_entry_t push_entry,
  output logic       head_valid,
  input  logic       pop,
  output run_entry_t head
);

  run_entry_t         q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QPTR_W:0]    count;

  assign push_ready = count != (QPTR_W+1)'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) q_mem[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/sbre_back.sv =====
module sbre_back
  import sbre_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             sector_is_4k,
  input  logic             head_valid,
  input  run_entry_t       head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OFS_W-1:0] out_start,
  output logic [OFS_W-1:0] out_end,
  output logic             out_alloc,
  output logic             out_last,
  output logic             out_ovf
);

  logic [BYTE_W-1:0] done, done_next;
  logic              mid, mid_next;
  idx_t              start_reg, start_reg_next;
  logic              out_valid_next;

  logic              slot_free;
  logic              step;
  logic              emit;
  logic              has_chg;
  logic [BYTE_W-1:0] rem;
  logic [BYTE_W-1:0] rem_after;
  logic [BYTE_W-1:0] p_onehot;
  logic [POS_W-1:0]  p;
  idx_t              cur_start;
  idx_t              chg_idx;
  idx_t              r_end;
  logic              r_alloc;

  function automatic logic [POS_W-1:0] lowest_set(logic [BYTE_W-1:0] m);
    logic [POS_W-1:0] r;
    r = '0;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      if (m[i]) r = POS_W'(i);
    end
    return r;
  endfunction

  function automatic logic [OFS_W-1:0] sector_offset(idx_t idx, logic is_4k);
    logic [OFS_W-1:0] wide;
    wide = OFS_W'(idx);
    return is_4k ? (wide << 12) : (wide << 9);
  endfunction

  always_comb begin
    slot_free = !out_valid || out_ready;
    rem       = head.chg & ~done;
    has_chg   = rem != '0;
    p         = lowest_set(rem);
    p_onehot  = BYTE_W'(1) << p;
    rem_after = rem & ~p_onehot;
    cur_start = mid ? start_reg : head.run_start;
    chg_idx   = head.base + idx_t'(p);
    step      = head_valid && slot_free;
    emit      = step && (has_chg || head.fin);
    pop       = step && (has_chg ? (rem_after == '0 && !head.fin) : 1'b1);
    r_end     = has_chg ? chg_idx : head.end_index;
    r_alloc   = has_chg ? !head.flags[p] : head.final_bit;
  end

  always_comb begin
    done_next      = done;
    mid_next       = mid;
    start_reg_next = start_reg;
    if (pop) begin
      done_next = '0;
      mid_next  = 1'b0;
    end else if (step && has_chg) begin
      done_next      = done | p_onehot;
      mid_next       = 1'b1;
      start_reg_next = chg_idx;
    end
    if (emit)           out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
    else                out_valid_next = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done      <= '0;
      mid       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      done      <= done_next;
      mid       <= mid_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    start_reg <= start_reg_next;
    if (emit) begin
      out_start <= sector_offset(cur_start, sector_is_4k);
      out_end   <= sector_offset(r_end, sector_is_4k);
      out_alloc <= r_alloc;
      out_last  <= !has_chg;
      out_ovf   <= head.ovf;
    end
  end

endmodule

// ===== sv/sector_bitmap_run_extractor.sv =====
// Sector bitmap run extractor. Bitmap bytes arrive on the s_ stream, eight
// sector flags each, and leave on the m_ stream as ranges of byte offsets
// (sector index times 512, or 4096 with sector_is_4k set), one range per
// change of flag value plus a closing range, marked by m_tlast, on the byte
// that carries s_tlast. The byte after a closing byte starts a new bitmap at
// sector 0. Bytes past 1048576 in one bitmap are dropped and raise the
// overflow flag in m_tuser. Rate: the front end classifies one byte per
// cycle into a four-entry queue while the queue has room; the range
// emitter drains the queue at one range per cycle while the receiver is
// ready, so a byte that yields several ranges holds the queue head until
// all of them have gone out. A range passes through the queue and the
// emitter's single output register before it is offered. Configuration
// must be written only while the block is idle; the block does not enforce it.
module sector_bitmap_run_extractor
  import sbre_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  // Configuration write port
  input  logic                    cfg_we,
  input  logic [CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  // Bitmap byte stream
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [7:0]              s_tdata,   // [7:0] bitmap_byte
  input  logic                    s_tlast,   // final_byte
  // Range stream
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [2*OFS_W-1:0]      m_tdata,   // [35:0] range_start, [71:36] range_end
  output logic                    m_tlast,   // last_range
  output logic [1:0]              m_tuser    // [0] allocated, [1] overflow
);

  logic msb_first;
  logic sector_is_4k;

  logic       push;
  logic       push_ready;
  run_entry_t push_entry;
  logic       head_valid;
  logic       pop;
  run_entry_t head;

  logic [OFS_W-1:0] out_start;
  logic [OFS_W-1:0] out_end;
  logic             out_alloc;
  logic             out_ovf;

  // Configuration registers; bit order is applied at classification, sector
  // size when the range is formed.
  always_ff @(posedge clk) begin
    if (rst) begin
      msb_first    <= 1'b1;
      sector_is_4k <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_addr))
        CFG_MSB_FIRST: msb_first    <= cfg_data[0];
        CFG_SECTOR_4K: sector_is_4k <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Front end: track the open run and classify each byte's flag changes.
  sbre_front u_front (
    .clk        (clk),
    .rst        (rst),
    .msb_first  (msb_first),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_byte    (s_tdata),
    .in_fin     (s_tlast),
    .push       (push),
    .push_ready (push_ready),
    .entry      (push_entry)
  );

  // Hold classified bytes so either side can stall on its own.
  sbre_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .head_valid (head_valid),
    .pop        (pop),
    .head       (head)
  );

  // Back end: walk the change mask, one range per transfer.
  sbre_back u_back (
    .clk          (clk),
    .rst          (rst),
    .sector_is_4k (sector_is_4k),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_start    (out_start),
    .out_end      (out_end),
    .out_alloc    (out_alloc),
    .out_last     (m_tlast),
    .out_ovf      (out_ovf)
  );

  assign m_tdata = {out_end, out_start};
  assign m_tuser = {out_ovf, out_alloc};

endmodule

// ===== sv/sbre_checker.sv =====
`include "assert_macros.svh"

module sbre_checker
  import sbre_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [2*OFS_W-1:0]    m_tdata,
  input logic                  m_tlast,
  input logic [1:0]            m_tuser
);

  logic [OFS_W-1:0]   r_start;
  logic [OFS_W-1:0]   r_end;
  logic [2*OFS_W+2:0] m_beat;

  assign r_start = m_tdata[OFS_W-1:0];
  assign r_end   = m_tdata[2*OFS_W-1:OFS_W];
  assign m_beat  = {m_tlast, m_tuser, m_tdata};

  // A pending range stays put until it transfers.
  `ASSERT_CLK(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_beat), "range dropped")

  // A range never ends before it starts.
  `ASSERT_CLK(a_order, m_tvalid |-> r_end >= r_start, "range reversed")

  // A range closed by a flag change holds at least one sector.
  `ASSERT_CLK(a_nonempty, m_tvalid && !m_tlast |-> r_end != r_start, "empty range")

  // Offsets sit on 512-byte boundaries.
  `ASSERT_CLK(a_align, m_tvalid |-> r_start[8:0] == 9'd0 && r_end[8:0] == 9'd0, "offset misaligned")

  // Reset leaves nothing to send.
  `ASSERT_CLK_ALWAYS(a_reset, rst |=> !m_tvalid, "output valid after reset")

endmodule

bind sector_bitmap_run_extractor sbre_checker u_checker (.*);

// ===== tb/sector_bitmap_run_extractor_tb.sv =====
`timescale 1ns / 1ps

module sector_bitmap_run_extractor_tb;
  import sbre_pkg::*;

  localparam int SETTLE_CYCLES = 16;    // emitter queue plus output register, with margin
  localparam int LONG_HOLD     = 300;   // receiver hold-off that backs the block up
  localparam int IDLE_LIMIT    = 4000;  // cycles without any transfer before giving up
  localparam int REPORT_MAX    = 40;

  // One bitmap byte as offered on the s_ stream.
  typedef struct packed {
    logic [7:0] bits;
    logic       fin;
  } bitmap_byte_t;

  // One range as it should appear on the m_ stream.
  typedef struct packed {
    logic [OFS_W-1:0] start_ofs;
    logic [OFS_W-1:0] end_ofs;
    logic             alloc;
    logic             last;
    logic             ovf;
  } range_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  cfg_index_t            cfg_addr = CFG_MSB_FIRST;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [2*OFS_W-1:0]    m_tdata;
  logic                  m_tlast;
  logic [1:0]            m_tuser;

  sector_bitmap_run_extractor DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // Bytes waiting to be offered, and ranges waiting to arrive.
  bitmap_byte_t byte_backlog[$];
  range_t       pending_ranges[$];

  int bytes_queued = 0;
  int bytes_taken  = 0;
  int mismatches   = 0;
  int idle_cycles  = 0;

  // Pacing controls, set by the stimulus process.
  logic quiet        = 1'b0;  // no gaps on either side
  logic hold_request = 1'b0;

  // Mirror of the block: configuration and run tracking.
  logic msb_order   = 1'b1;
  logic size_4k     = 1'b0;
  logic run_flag    = 1'b0;
  idx_t run_start   = '0;
  idx_t sec_count   = '0;
  logic open_bitmap = 1'b0;
  logic ovf_seen    = 1'b0;

  // Flag of the sector at position pos within a byte, in the current bit order.
  function automatic logic flag_of(input logic [7:0] bits, input int pos);
    return msb_order ? bits[7-pos] : bits[pos];
  endfunction

  // Byte offset of a sector index at the sector size now in force.
  function automatic logic [OFS_W-1:0] offset_of(input idx_t idx);
    logic [OFS_W-1:0] wide;
    wide = {{(OFS_W-IDX_W){1'b0}}, idx};
    return size_4k ? (wide << 12) : (wide << 9);
  endfunction

  task automatic close_run(input idx_t end_idx, input logic last);
    range_t r;
    r.start_ofs = offset_of(run_start);
    r.end_ofs   = offset_of(end_idx);
    r.alloc     = run_flag;
    r.last      = last;
    r.ovf       = ovf_seen;
    pending_ranges.push_back(r);
  endtask

  // Advance the mirror by one accepted byte and queue the ranges it closes.
  task automatic predict_ranges(input logic [7:0] bits, input logic fin);
    logic f;
    if (!open_bitmap) begin
      open_bitmap = 1'b1;
      run_flag    = flag_of(bits, 0);
      run_start   = '0;
      sec_count   = '0;
      ovf_seen    = 1'b0;
    end
    if (int'(sec_count) + BYTE_W > MAX_BITMAP_BYTES * BYTE_W) begin
      // Capacity reached: drop the byte's flags, remember the loss.
      ovf_seen = 1'b1;
    end else begin
      for (int p = 0; p < BYTE_W; p++) begin
        f = flag_of(bits, p);
        if (f != run_flag) begin
          close_run(sec_count, 1'b0);
          run_flag  = f;
          run_start = sec_count;
        end
        sec_count = sec_count + 1'b1;
      end
    end
    if (fin) begin
      close_run(sec_count, 1'b1);
      open_bitmap = 1'b0;
    end
  endtask

  task automatic check_field(input string what, input logic [OFS_W-1:0] want_v,
                             input logic [OFS_W-1:0] got_v);
    if (want_v !== got_v) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("%0t: %s expected %0h, got %0h", $time, what, want_v, got_v);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: sample both streams on the rising edge.
  // ---------------------------------------------------------------------------
  logic   byte_taken  = 1'b0;
  logic   range_taken = 1'b0;
  range_t want;

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predict_ranges(s_tdata, s_tlast);
        bytes_taken++;
        byte_taken = 1'b1;
      end
      if (m_tvalid && m_tready) begin
        range_taken = 1'b1;
        if (pending_ranges.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t: unexpected range, expected none, got %0h last %b user %b",
                     $time, m_tdata, m_tlast, m_tuser);
        end else begin
          want = pending_ranges.pop_front();
          check_field("range_start", want.start_ofs, m_tdata[OFS_W-1:0]);
          check_field("range_end", want.end_ofs, m_tdata[2*OFS_W-1:OFS_W]);
          check_field("allocated", OFS_W'(want.alloc), OFS_W'(m_tuser[0]));
          check_field("overflow", OFS_W'(want.ovf), OFS_W'(m_tuser[1]));
          check_field("last_range", OFS_W'(want.last), OFS_W'(m_tlast));
        end
      end
    end
  end

  // Watchdog: give up when no transfer has happened for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: offer backlog bytes on the falling edge, with a random gap
  // before each one.
  // ---------------------------------------------------------------------------
  int           gap_left = 0;
  logic         offer;
  bitmap_byte_t nxt;

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      offer = s_tvalid;
      if (byte_taken) begin
        byte_taken = 1'b0;
        offer      = 1'b0;
        gap_left   = quiet ? 0 : $urandom_range(0, 10);
      end
      if (!offer) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (byte_backlog.size() != 0) begin
          nxt = byte_backlog.pop_front();
          s_tdata <= nxt.bits;
          s_tlast <= nxt.fin;
          offer = 1'b1;
        end
      end
      // Single update per edge so valid stays high across back-to-back bytes.
      s_tvalid <= offer;
    end
  end

  // Receiver: stall for a random number of cycles after each range, and
  // hold off for a long stretch on request.
  int stall_left = 0;
  int hold_left  = 0;

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD;
      end
      if (range_taken) begin
        range_taken = 1'b0;
        stall_left  = quiet ? 0 : $urandom_range(0, 10);
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] bits, input logic fin);
    bitmap_byte_t b;
    b.bits = bits;
    b.fin  = fin;
    byte_backlog.push_back(b);
    bytes_queued++;
  endtask

  // Write one register; only called with the block idle.
  task automatic write_reg(input cfg_index_t idx, input logic val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MSB_FIRST)
      msb_order = val;
    else
      size_4k = val;
  endtask

  // Wait until every byte has transferred and every range has arrived, then
  // let bytes that close no run work through the block.
  task automatic drain();
    while (bytes_taken != bytes_queued || pending_ranges.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] random_bits();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'hFF >> $urandom_range(0, 7);   // at most one edge inside the byte
      3:       return 8'hFF << $urandom_range(0, 7);
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Queue whole bitmaps of random length and content; optionally leave one
  // open so that the next phase continues it under new settings.
  task automatic random_phase(input int n_bytes, input logic leave_open);
    int len;
    int sent;
    sent = 0;
    while (sent < n_bytes) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 6);
      for (int i = 0; i < len; i++)
        push_byte(random_bits(), i == len - 1);
      sent += len;
    end
    if (leave_open) begin
      push_byte(random_bits(), 1'b0);
      push_byte(random_bits(), 1'b0);
    end
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset settings, MSB first with 512 byte sectors.
    push_byte(8'h00, 1'b1);   // single unallocated run
    push_byte(8'hFF, 1'b1);   // single allocated run
    push_byte(8'hAA, 1'b1);   // alternating flags
    push_byte(8'h55, 1'b1);
    push_byte(8'h00, 1'b0);   // open run of zeros, then nine ranges from one byte
    push_byte(8'hAA, 1'b1);
    push_byte(8'h0F, 1'b0);   // runs crossing byte boundaries
    push_byte(8'hF0, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h80, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h7F, 1'b1);
    drain();

    // LSB first, 4096 byte sectors; leave a bitmap open across two changes.
    write_reg(CFG_MSB_FIRST, 1'b0);
    write_reg(CFG_SECTOR_4K, 1'b1);
    push_byte(8'h01, 1'b1);
    push_byte(8'h80, 1'b0);
    push_byte(8'h3C, 1'b0);
    drain();
    write_reg(CFG_MSB_FIRST, 1'b1);   // new bit order for the rest of the bitmap
    push_byte(8'hC3, 1'b0);
    drain();
    write_reg(CFG_SECTOR_4K, 1'b0);   // open run reported at the new size
    push_byte(8'hFE, 1'b1);
    drain();

    // Random phases over all settings.
    random_phase(100, 1'b0);

    write_reg(CFG_MSB_FIRST, 1'b0);
    write_reg(CFG_SECTOR_4K, 1'b1);
    quiet = 1'b1;
    random_phase(100, 1'b0);

    // Back-pressure: receiver holds off while the sender keeps offering.
    write_reg(CFG_MSB_FIRST, 1'b1);
    hold_request = 1'b1;
    random_phase(100, 1'b1);
    quiet = 1'b0;

    write_reg(CFG_MSB_FIRST, 1'b0);
    write_reg(CFG_SECTOR_4K, 1'b0);
    random_phase(100, 1'b0);

    // The next bitmap starts clean.
    push_byte(8'hA5, 1'b0);
    push_byte(8'h5A, 1'b1);
    drain();

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
